[src/hsv2rgb_pkg.sv]
package hsv2rgb_pkg;

   localparam int HueWidth   = 9;
   localparam int PctWidth   = 7;
   localparam int ChanWidth  = 8;
   localparam int FracWidth  = 6;

   localparam logic [HueWidth-1:0] HueFull = 9'd360;
   localparam logic [PctWidth-1:0] PctMax  = 7'd100;

   // floor(x / 100) = (x * 5243) >> 19 for x up to 25500
   localparam logic [12:0] RecipHundred = 13'd5243;
   localparam int          ShiftHundred = 19;

   // floor(x / 60) = (x * 17477) >> 20 for x up to 15045
   localparam logic [14:0] RecipSixty = 15'd17477;
   localparam int          ShiftSixty = 20;

   typedef logic [2:0] sector_type;

   localparam sector_type SectorRed     = 3'd0;
   localparam sector_type SectorYellow  = 3'd1;
   localparam sector_type SectorGreen   = 3'd2;
   localparam sector_type SectorCyan    = 3'd3;
   localparam sector_type SectorBlue    = 3'd4;
   localparam sector_type SectorMagenta = 3'd5;

endpackage

[src/hsv_to_rgb_converter_top.sv]
// hsv to rgb colour converter, seven register stages
// the start transfer is carried through the stage valid bits to the rsp_valid strobe
// throughput: one colour per cycle, busy is never raised; the rate is set by the pipeline
// and its three constant multipliers, one per stage
// reset (synchronous, active high) clears the stage valid bits only, the data path needs none
// the receiver cannot stall: each result is shown for exactly one cycle
module hsv_to_rgb_converter_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [hsv2rgb_pkg::HueWidth-1:0]  req_hue,
   input  logic [hsv2rgb_pkg::PctWidth-1:0]  req_saturation,
   input  logic [hsv2rgb_pkg::PctWidth-1:0]  req_brightness,
   output logic                              rsp_valid,
   output logic [hsv2rgb_pkg::ChanWidth-1:0] rsp_red,
   output logic [hsv2rgb_pkg::ChanWidth-1:0] rsp_green,
   output logic [hsv2rgb_pkg::ChanWidth-1:0] rsp_blue
);
   import hsv2rgb_pkg::*;

   // one valid bit per stage, shifted along with the data
   logic [6:0] valid_ff;
   logic [6:0] valid_in;

   // stage 1: wrapped hue split into sector and offset, clamped inputs
   sector_type               s1_sector_ff, s1_sector_in;
   logic [FracWidth-1:0]     s1_frac_ff,   s1_frac_in;
   logic [14:0]              s1_vprod_ff,  s1_vprod_in;
   logic [PctWidth-1:0]      s1_sinv_ff,   s1_sinv_in;

   // stage 2: top = floor(v * 255 / 100)
   sector_type               s2_sector_ff;
   logic [FracWidth-1:0]     s2_frac_ff;
   logic [PctWidth-1:0]      s2_sinv_ff;
   logic [ChanWidth-1:0]     s2_top_ff, s2_top_in;

   // stage 3: top * (100 - s)
   sector_type               s3_sector_ff;
   logic [FracWidth-1:0]     s3_frac_ff;
   logic [ChanWidth-1:0]     s3_top_ff;
   logic [14:0]              s3_botp_ff, s3_botp_in;

   // stage 4: bot and the span between bot and top
   sector_type               s4_sector_ff;
   logic [FracWidth-1:0]     s4_frac_ff;
   logic [ChanWidth-1:0]     s4_top_ff;
   logic [ChanWidth-1:0]     s4_bot_ff,  s4_bot_in;
   logic [ChanWidth-1:0]     s4_diff_ff, s4_diff_in;

   // stage 5: span * hue offset
   sector_type               s5_sector_ff;
   logic [ChanWidth-1:0]     s5_top_ff;
   logic [ChanWidth-1:0]     s5_bot_ff;
   logic [13:0]              s5_adjp_ff, s5_adjp_in;

   // stage 6: adj = floor(span * offset / 60)
   sector_type               s6_sector_ff;
   logic [ChanWidth-1:0]     s6_top_ff;
   logic [ChanWidth-1:0]     s6_bot_ff;
   logic [ChanWidth-1:0]     s6_adj_ff, s6_adj_in;

   // stage 7: output registers
   logic [ChanWidth-1:0]     red_ff,   red_in;
   logic [ChanWidth-1:0]     green_ff, green_in;
   logic [ChanWidth-1:0]     blue_ff,  blue_in;

   logic [HueWidth-1:0]      hue_wrap;
   logic [PctWidth-1:0]      sat_clamp;
   logic [PctWidth-1:0]      val_clamp;
   logic [HueWidth-1:0]      sector_base;
   logic [HueWidth-1:0]      hue_off;
   logic [27:0]              top_prod;
   logic [27:0]              bot_prod;
   logic [28:0]              adj_prod;
   logic [ChanWidth-1:0]     rise;
   logic [ChanWidth-1:0]     fall;

   assign busy = 1'b0;

   assign valid_in = {valid_ff[5:0], start};

   // stage 1 logic
   always_comb begin
      hue_wrap  = (req_hue >= HueFull) ? req_hue - HueFull : req_hue;
      sat_clamp = (req_saturation > PctMax) ? PctMax : req_saturation;
      val_clamp = (req_brightness > PctMax) ? PctMax : req_brightness;

      // sector search over the five boundaries
      if (hue_wrap >= 9'd300) begin
         s1_sector_in = SectorMagenta;
         sector_base  = 9'd300;
      end else if (hue_wrap >= 9'd240) begin
         s1_sector_in = SectorBlue;
         sector_base  = 9'd240;
      end else if (hue_wrap >= 9'd180) begin
         s1_sector_in = SectorCyan;
         sector_base  = 9'd180;
      end else if (hue_wrap >= 9'd120) begin
         s1_sector_in = SectorGreen;
         sector_base  = 9'd120;
      end else if (hue_wrap >= 9'd60) begin
         s1_sector_in = SectorYellow;
         sector_base  = 9'd60;
      end else begin
         s1_sector_in = SectorRed;
         sector_base  = 9'd0;
      end
      hue_off     = hue_wrap - sector_base;
      s1_frac_in  = hue_off[FracWidth-1:0];

      // v * 255 as (v << 8) - v
      s1_vprod_in = ({8'd0, val_clamp} << 8) - {8'd0, val_clamp};
      s1_sinv_in  = PctMax - sat_clamp;
   end

   // stages 2 to 6: one constant or narrow multiplier each
   always_comb begin
      top_prod   = {13'd0, s1_vprod_ff} * {15'd0, RecipHundred};
      s2_top_in  = top_prod[ShiftHundred+ChanWidth-1:ShiftHundred];

      s3_botp_in = {7'd0, s2_top_ff} * {8'd0, s2_sinv_ff};

      bot_prod   = {13'd0, s3_botp_ff} * {15'd0, RecipHundred};
      s4_bot_in  = bot_prod[ShiftHundred+ChanWidth-1:ShiftHundred];
      s4_diff_in = s3_top_ff - s4_bot_in;

      s5_adjp_in = {6'd0, s4_diff_ff} * {8'd0, s4_frac_ff};

      adj_prod   = {15'd0, s5_adjp_ff} * {14'd0, RecipSixty};
      s6_adj_in  = adj_prod[ShiftSixty+ChanWidth-1:ShiftSixty];
   end

   // stage 7: route top, bot and the ramps to the channels
   always_comb begin
      rise = s6_bot_ff + s6_adj_ff;
      fall = s6_top_ff - s6_adj_ff;
      case (s6_sector_ff)
         SectorRed: begin
            red_in = s6_top_ff; green_in = rise;      blue_in = s6_bot_ff;
         end
         SectorYellow: begin
            red_in = fall;      green_in = s6_top_ff; blue_in = s6_bot_ff;
         end
         SectorGreen: begin
            red_in = s6_bot_ff; green_in = s6_top_ff; blue_in = rise;
         end
         SectorCyan: begin
            red_in = s6_bot_ff; green_in = fall;      blue_in = s6_top_ff;
         end
         SectorBlue: begin
            red_in = rise;      green_in = s6_bot_ff; blue_in = s6_top_ff;
         end
         default: begin
            red_in = s6_top_ff; green_in = s6_bot_ff; blue_in = fall;
         end
      endcase
   end

   // control: valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // data path: no reset needed
   always_ff @(posedge clock) begin
      s1_sector_ff <= s1_sector_in;
      s1_frac_ff   <= s1_frac_in;
      s1_vprod_ff  <= s1_vprod_in;
      s1_sinv_ff   <= s1_sinv_in;

      s2_sector_ff <= s1_sector_ff;
      s2_frac_ff   <= s1_frac_ff;
      s2_sinv_ff   <= s1_sinv_ff;
      s2_top_ff    <= s2_top_in;

      s3_sector_ff <= s2_sector_ff;
      s3_frac_ff   <= s2_frac_ff;
      s3_top_ff    <= s2_top_ff;
      s3_botp_ff   <= s3_botp_in;

      s4_sector_ff <= s3_sector_ff;
      s4_frac_ff   <= s3_frac_ff;
      s4_top_ff    <= s3_top_ff;
      s4_bot_ff    <= s4_bot_in;
      s4_diff_ff   <= s4_diff_in;

      s5_sector_ff <= s4_sector_ff;
      s5_top_ff    <= s4_top_ff;
      s5_bot_ff    <= s4_bot_ff;
      s5_adjp_ff   <= s5_adjp_in;

      s6_sector_ff <= s5_sector_ff;
      s6_top_ff    <= s5_top_ff;
      s6_bot_ff    <= s5_bot_ff;
      s6_adj_ff    <= s6_adj_in;

      red_ff       <= red_in;
      green_ff     <= green_in;
      blue_ff      <= blue_in;
   end

   assign rsp_valid = valid_ff[6];
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

endmodule

[bench/hsv_to_rgb_converter_top_test.sv]
module hsv_to_rgb_converter_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import hsv2rgb_pkg::*;

   // run length, drain allowance and reset length
   localparam int unsigned CycleLimit   = 200000;
   localparam int unsigned DrainCycles  = 16;
   localparam int unsigned ResetCycles  = 6;

   // arithmetic constants of the conversion
   localparam int unsigned SectorSpan   = 60;
   localparam int unsigned ChanFull     = 255;
   localparam int unsigned Hundred      = 100;

   typedef struct packed {
      logic [ChanWidth-1:0] red;
      logic [ChanWidth-1:0] green;
      logic [ChanWidth-1:0] blue;
   } rgb_type;

   // expected colours in transfer order, checked against each strobe
   class colour_scoreboard;
      rgb_type     pending_rgb[$];
      int unsigned errors;

      function new();
         errors = 0;
      endfunction

      function rgb_type predict_rgb(logic [HueWidth-1:0] hue,
                                    logic [PctWidth-1:0] sat,
                                    logic [PctWidth-1:0] bri);
         int unsigned h, s, v, top, bot, adj, frac;
         sector_type  sector;
         rgb_type     rgb;
         h = hue;
         s = (sat > PctMax) ? PctMax : sat;
         v = (bri > PctMax) ? PctMax : bri;
         // hue wraps once, it never exceeds 511
         if (h >= HueFull) h = h - HueFull;
         sector = sector_type'(h / SectorSpan);
         frac   = h % SectorSpan;
         top    = (v * ChanFull) / Hundred;
         bot    = (top * (Hundred - s)) / Hundred;
         adj    = ((top - bot) * frac) / SectorSpan;
         case (sector)
            SectorRed: begin
               rgb.red = top[7:0];       rgb.green = 8'(bot + adj); rgb.blue = bot[7:0];
            end
            SectorYellow: begin
               rgb.red = 8'(top - adj);  rgb.green = top[7:0];      rgb.blue = bot[7:0];
            end
            SectorGreen: begin
               rgb.red = bot[7:0];       rgb.green = top[7:0];      rgb.blue = 8'(bot + adj);
            end
            SectorCyan: begin
               rgb.red = bot[7:0];       rgb.green = 8'(top - adj); rgb.blue = top[7:0];
            end
            SectorBlue: begin
               rgb.red = 8'(bot + adj);  rgb.green = bot[7:0];      rgb.blue = top[7:0];
            end
            default: begin
               rgb.red = top[7:0];       rgb.green = bot[7:0];      rgb.blue = 8'(top - adj);
            end
         endcase
         return rgb;
      endfunction

      function void note_colour(logic [HueWidth-1:0] hue,
                                logic [PctWidth-1:0] sat,
                                logic [PctWidth-1:0] bri);
         pending_rgb.push_back(predict_rgb(hue, sat, bri));
      endfunction

      function void check_colour(rgb_type got);
         rgb_type want;
         if (pending_rgb.size() == 0) begin
            $error("unexpected result red %0d green %0d blue %0d",
                   got.red, got.green, got.blue);
            errors++;
            return;
         end
         want = pending_rgb.pop_front();
         if (got.red !== want.red) begin
            $error("red: expected %0d, actual %0d", want.red, got.red);
            errors++;
         end
         if (got.green !== want.green) begin
            $error("green: expected %0d, actual %0d", want.green, got.green);
            errors++;
         end
         if (got.blue !== want.blue) begin
            $error("blue: expected %0d, actual %0d", want.blue, got.blue);
            errors++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [HueWidth-1:0]  req_hue;
   logic [PctWidth-1:0]  req_saturation;
   logic [PctWidth-1:0]  req_brightness;
   logic                 rsp_valid;
   logic [ChanWidth-1:0] rsp_red;
   logic [ChanWidth-1:0] rsp_green;
   logic [ChanWidth-1:0] rsp_blue;

   colour_scoreboard colour_board;
   int unsigned      cycle_count;

   hsv_to_rgb_converter_top dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   // 2 ns clock
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // known values on every input from time zero
   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_hue        = '0;
      req_saturation = '0;
      req_brightness = '0;
      colour_board   = new();
      cycle_count    = 0;
   end

   // watchdog: a hung pipeline or a lost result ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // monitor: values read here are those held through the cycle ending at this edge
   always @(posedge clock) begin
      if (!reset) begin
         // input transfer: start high while busy low
         if (start && !busy)
            colour_board.note_colour(req_hue, req_saturation, req_brightness);
         // result strobe lasts one cycle, no back-pressure possible
         if ($isunknown(rsp_valid)) begin
            $error("rsp_valid unknown after reset");
            colour_board.errors++;
         end else if (rsp_valid) begin
            colour_board.check_colour('{red: rsp_red, green: rsp_green, blue: rsp_blue});
         end
      end
   end

   // present one colour and hold it until the transfer edge
   task automatic send_colour(input logic [HueWidth-1:0] hue,
                              input logic [PctWidth-1:0] sat,
                              input logic [PctWidth-1:0] bri);
      req_hue        <= hue;
      req_saturation <= sat;
      req_brightness <= bri;
      start          <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // optional gap before the next colour, idle_pct in percent of cycles
   task automatic maybe_idle(input int unsigned idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // random colours: mostly nominal ranges, the rest over the full port widths
   task automatic send_random(input int unsigned count, input int unsigned idle_pct);
      logic [HueWidth-1:0] hue;
      logic [PctWidth-1:0] sat;
      logic [PctWidth-1:0] bri;
      repeat (count) begin
         if ($urandom_range(99) < 70) begin
            hue = HueWidth'($urandom_range(0, 359));
            sat = PctWidth'($urandom_range(0, 100));
            bri = PctWidth'($urandom_range(0, 100));
         end else begin
            hue = HueWidth'($urandom_range(0, 511));
            sat = PctWidth'($urandom_range(0, 127));
            bri = PctWidth'($urandom_range(0, 127));
         end
         maybe_idle(idle_pct);
         send_colour(hue, sat, bri);
      end
   endtask

   initial begin
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: black, white, full and muted colours
      send_colour(9'd0,   7'd0,   7'd0);
      send_colour(9'd0,   7'd0,   7'd100);
      send_colour(9'd0,   7'd100, 7'd100);
      // sector edges, each sector at its first and last degree
      send_colour(9'd59,  7'd100, 7'd100);
      send_colour(9'd60,  7'd100, 7'd100);
      send_colour(9'd119, 7'd100, 7'd100);
      send_colour(9'd120, 7'd100, 7'd100);
      send_colour(9'd179, 7'd75,  7'd100);
      send_colour(9'd180, 7'd75,  7'd90);
      send_colour(9'd239, 7'd50,  7'd80);
      send_colour(9'd240, 7'd100, 7'd100);
      send_colour(9'd299, 7'd100, 7'd100);
      send_colour(9'd300, 7'd100, 7'd100);
      send_colour(9'd359, 7'd100, 7'd100);
      // hue wrap into red and beyond
      send_colour(9'd360, 7'd100, 7'd100);
      send_colour(9'd419, 7'd100, 7'd100);
      send_colour(9'd511, 7'd100, 7'd100);
      // saturation and brightness above 100 clamp
      send_colour(9'd30,  7'd101, 7'd50);
      send_colour(9'd200, 7'd127, 7'd127);
      send_colour(9'd90,  7'd40,  7'd101);
      send_colour(9'd511, 7'd127, 7'd127);
      // low brightness, small ramp values
      send_colour(9'd45,  7'd100, 7'd1);
      send_colour(9'd333, 7'd1,   7'd99);

      // random phases: sender idles seldom, then often, then back to back
      send_random(320, 21);
      send_random(320, 82);
      send_random(310, 0);
      start <= 1'b0;

      // drain the pipeline, then allow its latency again
      while (colour_board.pending_rgb.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (colour_board.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
src/hsv2rgb_pkg.sv
src/hsv_to_rgb_converter_top.sv
bench/hsv_to_rgb_converter_top_test.sv
